[rtl/tcd_pkg.sv]
`default_nettype none

package tcd_pkg;

	// Default number of columns of the triangular factor.
	localparam int MAX_COLS_DEF = 16;

	localparam int DATA_W = 32;
	localparam int FRAC_W = 16;

	// Request kinds.
	localparam logic [1:0] KIND_WRITE  = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_SET    = 2'd2;
	localparam logic [1:0] KIND_DELETE = 2'd3;

	// Result kinds.
	localparam logic RESP_READ   = 1'b0;
	localparam logic RESP_DELETE = 1'b1;

	typedef struct packed {
		logic [1:0]               kind;
		logic [7:0]               position;
		logic signed [DATA_W-1:0] value;
		logic [4:0]               count;
		logic [4:0]               column;
	} req_t;

	typedef struct packed {
		logic                     resp_kind;
		logic signed [DATA_W-1:0] read_value;
		logic [4:0]               cols_now;
		logic                     zero_norm;
	} resp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_READ_OUT,
		S_COL_RD1,
		S_COL_RD2,
		S_SQ1,
		S_SQ2,
		S_SQ3,
		S_ROOT_GO,
		S_ROOT_WAIT,
		S_DIAG_WR,
		S_DIV1_WAIT,
		S_DIV2_WAIT,
		S_ROT_RDA,
		S_ROT_RDB,
		S_ROT_M1,
		S_ROT_M2,
		S_ROT_M3,
		S_ROT_M4,
		S_ROT_M5,
		S_ROT_W2,
		S_CP_RD,
		S_CP_WR,
		S_DEL_DONE
	} state_t;

	typedef enum logic [1:0] {
		WSRC_REQ,
		WSRC_DIAG,
		WSRC_ROT,
		WSRC_RDATA
	} wsrc_t;

	typedef enum logic [2:0] {
		MUL_T1T1,
		MUL_T2T2,
		MUL_CSA,
		MUL_SNB,
		MUL_SNA,
		MUL_CSB
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		logic     rd_en;
		logic     wr_en;
		wsrc_t    wsrc;
		logic     ld_t1;
		logic     ld_t2;
		logic     ld_a;
		logic     ld_b;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     root_start;
		logic     div_start;
		logic     div_sel_t2;
		logic     ld_cs;
		logic     ld_sn;
		logic     cs_unit;
		logic     emit;
		logic     emit_del;
		logic     rd_ok;
		logic [4:0] cols_now;
		logic     zero_norm;
	} ctrl_cmd_t;

	typedef struct packed {
		logic root_done;
		logic div_done;
		logic d_zero;
	} dp_status_t;

endpackage

`default_nettype wire

[rtl/tcd_root.sv]
`default_nettype none

module tcd_root (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] v,
	output logic             done,
	output logic [31:0]      res
);
	import tcd_pkg::*;

	// Digit-by-digit square root, one result bit per cycle.
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [4:0]  k_q;
	logic        run_q;
	logic        done_q;
	logic [63:0] bit_w;
	logic [63:0] trial;

	assign bit_w = 64'd1 << {k_q, 1'b0};
	assign trial = res_q + bit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				k_q   <= 5'd31;
			end else if (run_q) begin
				if (k_q == 5'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					k_q <= k_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= v;
			res_q <= '0;
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_w;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q[31:0];

endmodule

`default_nettype wire

[rtl/tcd_div.sv]
`default_nettype none

module tcd_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] mag,
	input  wire logic        neg,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic signed [31:0] quot
);
	import tcd_pkg::*;

	// Restoring division of mag * 2^16 by divisor, one quotient bit per cycle.
	// The quotient magnitude never exceeds one in fixed point.
	localparam int DVD_W = DATA_W + FRAC_W;

	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] q_q;
	logic [31:0]      rem_q;
	logic [31:0]      den_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic             run_q;
	logic             done_q;
	logic [32:0]      trial;
	logic             qbit;
	logic [31:0]      q_mag;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'(DVD_W - 1);
			end else if (run_q) begin
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, {FRAC_W{1'b0}}};
			q_q   <= '0;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= neg;
		end else if (run_q) begin
			dvd_q <= dvd_q << 1;
			q_q   <= {q_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
		end
	end

	assign q_mag = 32'(q_q[FRAC_W:0]);
	assign quot  = neg_q ? -$signed(q_mag) : $signed(q_mag);
	assign done  = done_q;

endmodule

`default_nettype wire

[rtl/tcd_dpath.sv]
`default_nettype none

module tcd_dpath #(
	parameter int MAX_COLS = tcd_pkg::MAX_COLS_DEF,
	parameter int IDX_W    = $clog2(MAX_COLS * (MAX_COLS + 1) / 2)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire tcd_pkg::req_t         req,
	input  wire tcd_pkg::ctrl_cmd_t    cmd,
	input  wire logic [IDX_W-1:0]      rd_addr,
	input  wire logic [IDX_W-1:0]      wr_addr,
	output tcd_pkg::dp_status_t        status,
	output logic                       done,
	output tcd_pkg::resp_t             resp
);
	import tcd_pkg::*;

	localparam int TRI = MAX_COLS * (MAX_COLS + 1) / 2;

	logic signed [DATA_W-1:0] mem [TRI];
	logic signed [DATA_W-1:0] rdata_q;
	logic signed [DATA_W-1:0] wdata;

	logic signed [DATA_W-1:0] t1_q, t2_q, a_q, b_q, cs_q, sn_q;
	logic signed [DATA_W-1:0] op_a, op_b;
	logic signed [63:0]       mul_p;
	logic signed [63:0]       prod_q;
	logic signed [64:0]       acc_q;
	logic signed [64:0]       rnd_y, rnd_s;
	logic signed [DATA_W-1:0] rot_sat;
	logic [31:0]              root_res;
	logic                     root_done;
	logic signed [DATA_W-1:0] diag_sat;
	logic signed [DATA_W-1:0] div_src;
	logic [31:0]              div_mag;
	logic                     div_done;
	logic signed [31:0]       div_quot;
	resp_t                    resp_q;
	logic                     done_q;

	// Rounding to nearest with halves upward, then clamping.
	assign rnd_y = acc_q + 65'sd32768;
	assign rnd_s = rnd_y >>> FRAC_W;
	always_comb begin
		if (rnd_s > 65'sd2147483647) begin
			rot_sat = 32'sh7FFFFFFF;
		end else if (rnd_s < -65'sd2147483648) begin
			rot_sat = 32'sh80000000;
		end else begin
			rot_sat = 32'(rnd_s);
		end
	end

	assign diag_sat = root_res[31] ? 32'sh7FFFFFFF : $signed(root_res);

	always_comb begin
		case (cmd.wsrc)
			WSRC_REQ:   wdata = req.value;
			WSRC_DIAG:  wdata = diag_sat;
			WSRC_ROT:   wdata = rot_sat;
			WSRC_RDATA: wdata = rdata_q;
			default:    wdata = rdata_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			MUL_T1T1: begin op_a = t1_q; op_b = t1_q; end
			MUL_T2T2: begin op_a = t2_q; op_b = t2_q; end
			MUL_CSA:  begin op_a = cs_q; op_b = a_q;  end
			MUL_SNB:  begin op_a = sn_q; op_b = b_q;  end
			MUL_SNA:  begin op_a = sn_q; op_b = a_q;  end
			MUL_CSB:  begin op_a = cs_q; op_b = b_q;  end
			default:  begin op_a = t1_q; op_b = t1_q; end
		endcase
	end

	assign mul_p = op_a * op_b;

	always_ff @(posedge clk) begin
		if (cmd.ld_t1) t1_q <= rdata_q;
		if (cmd.ld_t2) t2_q <= rdata_q;
		if (cmd.ld_a) a_q <= rdata_q;
		if (cmd.ld_b) b_q <= rdata_q;
		if (cmd.mul_en) prod_q <= mul_p;
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= 65'(prod_q);
			ACC_ADD:  acc_q <= acc_q + 65'(prod_q);
			ACC_SUB:  acc_q <= acc_q - 65'(prod_q);
			default:  acc_q <= acc_q;
		endcase
		if (cmd.cs_unit) begin
			cs_q <= 32'sd65536;
			sn_q <= 32'sd0;
		end else begin
			if (cmd.ld_cs) cs_q <= div_quot;
			if (cmd.ld_sn) sn_q <= div_quot;
		end
	end

	tcd_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.root_start),
		.v      (acc_q[63:0]),
		.done   (root_done),
		.res    (root_res)
	);

	assign div_src = cmd.div_sel_t2 ? t2_q : t1_q;
	assign div_mag = div_src[31] ? (~div_src + 32'd1) : div_src;

	tcd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.mag     (div_mag),
		.neg     (div_src[31]),
		.divisor (root_res),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign status.root_done = root_done;
	assign status.div_done  = div_done;
	assign status.d_zero    = (root_res == 32'd0);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			resp_q.resp_kind  <= cmd.emit_del ? RESP_DELETE : RESP_READ;
			resp_q.read_value <= (!cmd.emit_del && cmd.rd_ok) ? rdata_q : 32'sd0;
			resp_q.cols_now   <= cmd.cols_now;
			resp_q.zero_norm  <= cmd.zero_norm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign done = done_q;
	assign resp = resp_q;

endmodule

`default_nettype wire

[rtl/tcd_ctrl.sv]
`default_nettype none

module tcd_ctrl #(
	parameter int MAX_COLS = tcd_pkg::MAX_COLS_DEF,
	parameter int IDX_W    = $clog2(MAX_COLS * (MAX_COLS + 1) / 2)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire tcd_pkg::req_t       req,
	input  wire tcd_pkg::dp_status_t status,
	output logic                     busy,
	output tcd_pkg::ctrl_cmd_t       cmd,
	output logic [IDX_W-1:0]         rd_addr,
	output logic [IDX_W-1:0]         wr_addr
);
	import tcd_pkg::*;

	localparam int TRI = MAX_COLS * (MAX_COLS + 1) / 2;
	localparam int CW  = $clog2(MAX_COLS + 2);
	localparam int NW  = $clog2(MAX_COLS + 1);
	localparam int AW  = $clog2(TRI + 1) + 1;

	state_t        state_q, state_d;
	logic [NW-1:0] active_q, active_d;
	logic          flag_q, flag_d;
	logic          rd_ok_q, rd_ok_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d, r_q, r_d;

	logic [AW-1:0]    tri_i, tri_j, tri_im1;
	logic [IDX_W-1:0] idx_t1, idx_t2, idx_a, idx_b, idx_src, idx_dst, pos_idx;
	logic             pos_ok;
	logic [4:0]       col_eff;
	logic             del_go;
	logic [NW-1:0]    cnt_sat, active_dec;

	function automatic logic [AW-1:0] tri_of(input logic [CW-1:0] n);
		logic [AW-1:0] m;
		m = AW'(n) * AW'(n - CW'(1));
		return m >> 1;
	endfunction

	assign tri_i   = tri_of(i_q);
	assign tri_j   = tri_of(j_q);
	assign tri_im1 = tri_of(i_q - CW'(1));

	assign idx_t1  = IDX_W'(tri_i + AW'(i_q) - AW'(2));
	assign idx_t2  = IDX_W'(tri_i + AW'(i_q) - AW'(1));
	assign idx_a   = IDX_W'(tri_j + AW'(i_q) - AW'(2));
	assign idx_b   = IDX_W'(tri_j + AW'(i_q) - AW'(1));
	assign idx_src = IDX_W'(tri_i + AW'(r_q) - AW'(1));
	assign idx_dst = IDX_W'(tri_im1 + AW'(r_q) - AW'(1));

	assign pos_ok  = (req.position != 8'd0) && (int'(req.position) <= TRI);
	assign pos_idx = IDX_W'(int'(req.position) - 1);

	assign col_eff    = (req.column == 5'd0) ? 5'd1 : req.column;
	assign del_go     = int'(col_eff) < int'(active_q);
	assign cnt_sat    = (int'(req.count) > MAX_COLS) ? NW'(MAX_COLS) : NW'(req.count);
	assign active_dec = (active_q == '0) ? '0 : active_q - NW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= '0;
			flag_q   <= 1'b0;
			rd_ok_q  <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			r_q      <= '0;
		end else begin
			state_q  <= state_d;
			active_q <= active_d;
			flag_q   <= flag_d;
			rd_ok_q  <= rd_ok_d;
			i_q      <= i_d;
			j_q      <= j_d;
			r_q      <= r_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		active_d = active_q;
		flag_d   = flag_q;
		rd_ok_d  = rd_ok_q;
		i_d      = i_q;
		j_d      = j_q;
		r_d      = r_q;
		cmd      = '0;
		rd_addr  = '0;
		wr_addr  = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.kind)
						KIND_WRITE: begin
							cmd.wr_en = pos_ok;
							cmd.wsrc  = WSRC_REQ;
							wr_addr   = pos_idx;
						end
						KIND_READ: begin
							cmd.rd_en = 1'b1;
							rd_addr   = pos_idx;
							rd_ok_d   = pos_ok;
							state_d   = S_READ_OUT;
						end
						KIND_SET: begin
							active_d = cnt_sat;
						end
						default: begin
							flag_d = 1'b0;
							if (del_go) begin
								i_d     = CW'(int'(col_eff) + 1);
								state_d = S_COL_RD1;
							end else begin
								state_d = S_DEL_DONE;
							end
						end
					endcase
				end
			end
			S_READ_OUT: begin
				cmd.emit     = 1'b1;
				cmd.rd_ok    = rd_ok_q;
				cmd.cols_now = 5'(active_q);
				state_d      = S_IDLE;
			end
			S_COL_RD1: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_t1;
				state_d   = S_COL_RD2;
			end
			S_COL_RD2: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_t2;
				cmd.ld_t1 = 1'b1;
				state_d   = S_SQ1;
			end
			S_SQ1: begin
				cmd.ld_t2   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_T1T1;
				state_d     = S_SQ2;
			end
			S_SQ2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_T2T2;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_SQ3;
			end
			S_SQ3: begin
				cmd.acc_op = ACC_ADD;
				state_d    = S_ROOT_GO;
			end
			S_ROOT_GO: begin
				cmd.root_start = 1'b1;
				state_d        = S_ROOT_WAIT;
			end
			S_ROOT_WAIT: begin
				if (status.root_done) begin
					state_d = S_DIAG_WR;
				end
			end
			S_DIAG_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wsrc  = WSRC_DIAG;
				wr_addr   = idx_t1;
				if (i_q < CW'(active_q)) begin
					if (status.d_zero) begin
						cmd.cs_unit = 1'b1;
						flag_d      = 1'b1;
						j_d         = i_q + CW'(1);
						state_d     = S_ROT_RDA;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV1_WAIT;
					end
				end else begin
					r_d     = CW'(1);
					state_d = S_CP_RD;
				end
			end
			S_DIV1_WAIT: begin
				if (status.div_done) begin
					cmd.ld_cs      = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_sel_t2 = 1'b1;
					state_d        = S_DIV2_WAIT;
				end
			end
			S_DIV2_WAIT: begin
				cmd.div_sel_t2 = 1'b1;
				if (status.div_done) begin
					cmd.ld_sn = 1'b1;
					j_d       = i_q + CW'(1);
					state_d   = S_ROT_RDA;
				end
			end
			S_ROT_RDA: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_a;
				state_d   = S_ROT_RDB;
			end
			S_ROT_RDB: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_b;
				cmd.ld_a  = 1'b1;
				state_d   = S_ROT_M1;
			end
			S_ROT_M1: begin
				cmd.ld_b    = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CSA;
				state_d     = S_ROT_M2;
			end
			S_ROT_M2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SNB;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_ROT_M3;
			end
			S_ROT_M3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SNA;
				cmd.acc_op  = ACC_ADD;
				state_d     = S_ROT_M4;
			end
			S_ROT_M4: begin
				cmd.wr_en   = 1'b1;
				cmd.wsrc    = WSRC_ROT;
				wr_addr     = idx_a;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CSB;
				cmd.acc_op  = ACC_LOAD;
				state_d     = S_ROT_M5;
			end
			S_ROT_M5: begin
				cmd.acc_op = ACC_SUB;
				state_d    = S_ROT_W2;
			end
			S_ROT_W2: begin
				cmd.wr_en = 1'b1;
				cmd.wsrc  = WSRC_ROT;
				wr_addr   = idx_b;
				if (j_q < CW'(active_q)) begin
					j_d     = j_q + CW'(1);
					state_d = S_ROT_RDA;
				end else begin
					r_d     = CW'(1);
					state_d = S_CP_RD;
				end
			end
			S_CP_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = idx_src;
				state_d   = S_CP_WR;
			end
			S_CP_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wsrc  = WSRC_RDATA;
				wr_addr   = idx_dst;
				if (r_q < i_q - CW'(1)) begin
					r_d     = r_q + CW'(1);
					state_d = S_CP_RD;
				end else if (i_q < CW'(active_q)) begin
					i_d     = i_q + CW'(1);
					state_d = S_COL_RD1;
				end else begin
					state_d = S_DEL_DONE;
				end
			end
			S_DEL_DONE: begin
				active_d      = active_dec;
				cmd.emit      = 1'b1;
				cmd.emit_del  = 1'b1;
				cmd.cols_now  = 5'(active_dec);
				cmd.zero_norm = flag_q;
				state_d       = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// Two results can never come in adjacent cycles.
	a_emit_gap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> !cmd.emit)
		else $error("result strobes in adjacent cycles");

	// The column under work stays inside the active part of the factor.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COL_RD1 || state_q == S_DIAG_WR || state_q == S_CP_WR)
		|-> (i_q >= CW'(2) && i_q <= CW'(active_q)))
		else $error("column index out of range during delete");

	// Rotation only touches columns right of the current one.
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROT_RDA) |-> (j_q > i_q && j_q <= CW'(active_q)))
		else $error("rotation column out of range");

	// The count never exceeds the capacity.
	a_active_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(active_q) <= MAX_COLS)
		else $error("active column count above capacity");

endmodule

`default_nettype wire

[rtl/triangular_column_delete_top.sv]
`default_nettype none

// Triangular factor store with column delete. Requests are taken on a rising
// edge with start high and busy low. A write or a set-count request is done
// at the edge that takes it and gives no result. A read gives its result
// through the memory read register and the result register. A delete of
// column p with n active columns works on each column from p+1 to n in
// turn: each moved column waits on the square root and, unless it is the
// last one, on each of two divisions, and all entry traffic goes through a
// single memory with one read and one write port. A rotation that meets a
// zero norm skips both divisions. Each result is shown on resp for exactly
// one cycle with done high; the receiver cannot hold it off and must take it
// in that cycle.
// Entries read before they were ever written return unspecified data; there
// is no clearing pass after reset.
module triangular_column_delete_top #(
	parameter int MAX_COLS = tcd_pkg::MAX_COLS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire tcd_pkg::req_t  req,
	output logic                busy,
	output logic                done,
	output tcd_pkg::resp_t      resp
);
	import tcd_pkg::*;

	// Width of a packed entry index.
	localparam int IDX_W = $clog2(MAX_COLS * (MAX_COLS + 1) / 2);

	ctrl_cmd_t        cmd;
	dp_status_t       status;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;

	// The controller sequences every request through the datapath: it owns the
	// active count, the loop counters and the address arithmetic.
	tcd_ctrl #(
		.MAX_COLS (MAX_COLS),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req     (req),
		.status  (status),
		.busy    (busy),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr)
	);

	// The datapath holds the entry memory, the multiplier, the accumulator,
	// the square root and divider units and the result register.
	tcd_dpath #(
		.MAX_COLS (MAX_COLS),
		.IDX_W    (IDX_W)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.status  (status),
		.done    (done),
		.resp    (resp)
	);

endmodule

`default_nettype wire
